[hdl/mope_pkg.sv]
// Shared types and constants of the matrix optimal path engine.
// Depends on nothing; imported by the engine top level.
package mope_pkg;

   // Fixed field widths of the item channels
   localparam int NODE_W      = 6;
   localparam int FIELD_W     = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 96;

   // Configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_DATA_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METRIC_MODE = 1'b0,
      CSR_NODE_COUNT  = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic {
      MODE_LATENCY   = 1'b0,
      MODE_BANDWIDTH = 1'b1
   } metric_mode_type;

endpackage

[hdl/mope_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mope_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; read data is registered and follows the address in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/matrix_optimal_path_engine.sv]
// Usage guide:
// The engine keeps an N by N matrix of 16.16 link metrics. Items enter on the
// req_ channel: req_tuser selects a matrix write or a query. A write in range
// is written as it is taken and gives no result. A query gives one result on the rsp_
// channel: the direct entry, the best path over at most one other node and
// the Bellman-Ford optimum. An item with a node index at or beyond N gives a
// result with rsp_tuser (index error) set and all metrics zero.
// In a query every relaxation step reads one matrix entry over the single
// matrix read port, and the two-hop scan reads two entries per node.
// req_tready is high while the engine is between items; a write or query is
// taken while an earlier result still waits in the output register. When the
// receiver stalls, a finished result holds in the engine until the output
// register frees up, and no new item is taken meanwhile.
// Reset (synchronous) clears the sequencer, the output valid, metric_mode to
// latency and node_count to NODE_COUNT_RESET. Matrix contents are undefined until written.
// The csr_ port writes metric_mode (index 0) or node_count (index 1) at any
// clock edge with csr_wr_en high; write it only while the engine is idle.
module matrix_optimal_path_engine
   import mope_pkg::*;
#(
   parameter int MAX_NODES   = 64,
   parameter int METRIC_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: src_node [5:0], dst_node [11:6], entry_value [43:12], zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: req_type
   input  logic                  req_tuser,
   // rsp_tdata: direct_metric [31:0], two_hop_metric [63:32], optimal_metric [95:64]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: index_error
   output logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;
   localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
   localparam logic [METRIC_BITS-1:0] INF = {METRIC_BITS{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_TWO_HOP, S_INIT, S_BF_LOAD, S_BF_RUN, S_BF_DRAIN,
      S_FINAL, S_CAPTURE, S_RESP
   } state_type;

   // What the read data of the memories belongs to, tagged at issue and used in the next cycle
   typedef enum logic [2:0] {
      TAG_NONE, TAG_DIRECT, TAG_HOP_A, TAG_HOP_B, TAG_CUR, TAG_RELAX, TAG_FINAL
   } tag_kind_type;

   typedef struct packed {
      tag_kind_type     kind;
      logic [IDX_W-1:0] idx;
   } rd_tag_type;

   // Combine two link metrics into a path metric
   function automatic logic [METRIC_BITS-1:0] chain_f(
      input logic bw, input logic [METRIC_BITS-1:0] a, input logic [METRIC_BITS-1:0] b);
      logic [METRIC_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (bw) begin
         return (a < b) ? a : b;
      end
      return sum[METRIC_BITS] ? INF : sum[METRIC_BITS-1:0];
   endfunction

   // True when the candidate strictly beats the current metric
   function automatic logic better_f(
      input logic bw, input logic [METRIC_BITS-1:0] cand,
      input logic [METRIC_BITS-1:0] cur);
      return bw ? (cand > cur) : (cand < cur);
   endfunction

   function automatic logic [AW-1:0] mat_addr(
      input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
      return AW'(r) * AW'(MAX_NODES) + AW'(c);
   endfunction

   // Configuration
   logic                  mode_ff;
   logic [CSR_DATA_W-1:0] node_count_ff;

   // Sequencer and datapath registers
   state_type             state_ff,     state_in;
   logic [IDX_W-1:0]      src_ff,       src_in;
   logic [IDX_W-1:0]      dst_ff,       dst_in;
   logic [IDX_W-1:0]      k_ff,         k_in;
   logic [IDX_W-1:0]      h_ff,         h_in;
   logic [IDX_W-1:0]      round_ff,     round_in;
   logic                  phase_ff,     phase_in;
   rd_tag_type            tag_ff,       tag_in;
   logic [METRIC_BITS-1:0] a_ff,        a_in;
   logic [METRIC_BITS-1:0] cur_ff,      cur_in;
   logic [METRIC_BITS-1:0] direct_ff,   direct_in;
   logic [METRIC_BITS-1:0] best_ff,     best_in;
   logic [METRIC_BITS-1:0] opt_ff,      opt_in;
   logic                  err_ff,       err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                  rsp_err_ff,   rsp_err_in;

   // Memory ports
   logic                   mat_we;
   logic [AW-1:0]          mat_wa, mat_ra;
   logic [METRIC_BITS-1:0] mat_wd, mat_rd;
   logic                   dv_we;
   logic [IDX_W-1:0]       dv_wa, dv_ra;
   logic [METRIC_BITS-1:0] dv_wd, dv_rd;

   // Derived values
   logic                   bw;
   logic [CMP_W-1:0]       n_w, nc_w, n_last;
   logic [NODE_W-1:0]      req_src, req_dst;
   logic                   req_err;
   logic                   last_k, last_h, last_round;
   logic [METRIC_BITS-1:0] hop_len, relax_dv, relax_x, init_dst, init_other;

   assign bw      = (mode_ff == MODE_BANDWIDTH);
   assign nc_w    = CMP_W'(node_count_ff);
   assign n_w     = (nc_w > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : nc_w;
   assign n_last  = n_w - CMP_W'(1);
   assign req_src = req_tdata[NODE_W-1:0];
   assign req_dst = req_tdata[2*NODE_W-1:NODE_W];
   assign req_err = (CMP_W'(req_src) >= n_w) || (CMP_W'(req_dst) >= n_w);

   assign last_k     = (CMP_W'(k_ff) == n_last);
   assign last_h     = (CMP_W'(h_ff) == n_last);
   assign last_round = (CMP_W'(round_ff) == n_last);

   assign hop_len    = chain_f(bw, a_ff, mat_rd);
   assign relax_dv   = (tag_ff.idx == k_ff) ? cur_ff : dv_rd;
   assign relax_x    = chain_f(bw, mat_rd, relax_dv);
   assign init_dst   = bw ? INF : '0;
   assign init_other = bw ? '0 : INF;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   mope_ram #(.WIDTH(METRIC_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_link_matrix (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wa),
      .wr_data (mat_wd),
      .rd_addr (mat_ra),
      .rd_data (mat_rd)
   );

   mope_ram #(.WIDTH(METRIC_BITS), .DEPTH(MAX_NODES)) u_distance_vector (
      .clock   (clock),
      .wr_en   (dv_we),
      .wr_addr (dv_wa),
      .wr_data (dv_wd),
      .rd_addr (dv_ra),
      .rd_data (dv_rd)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LATENCY;
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_METRIC_MODE: mode_ff       <= csr_wdata[0];
            CSR_NODE_COUNT:  node_count_ff <= csr_wdata;
         endcase
      end
   end

   // Next-state logic: consume read data by tag, then issue by state
   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      round_in     = round_ff;
      phase_in     = phase_ff;
      tag_in       = '{kind: TAG_NONE, idx: '0};
      a_in         = a_ff;
      cur_in       = cur_ff;
      direct_in    = direct_ff;
      best_in      = best_ff;
      opt_in       = opt_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      mat_we       = 1'b0;
      mat_wa       = mat_addr(IDX_W'(req_src), IDX_W'(req_dst));
      mat_wd       = METRIC_BITS'(req_tdata[2*NODE_W+FIELD_W-1:2*NODE_W]);
      mat_ra       = '0;
      dv_we        = 1'b0;
      dv_wa        = k_ff;
      dv_wd        = (k_ff == dst_ff) ? init_dst : init_other;
      dv_ra        = '0;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Consume the memory read issued last cycle
      case (tag_ff.kind)
         TAG_DIRECT: begin
            direct_in = mat_rd;
            best_in   = mat_rd;
         end
         TAG_HOP_A: a_in = mat_rd;
         TAG_HOP_B: begin
            if (tag_ff.idx != src_ff && tag_ff.idx != dst_ff &&
                better_f(bw, hop_len, best_ff)) begin
               best_in = hop_len;
            end
         end
         TAG_CUR:   cur_in = dv_rd;
         TAG_RELAX: begin
            if (better_f(bw, relax_x, cur_ff)) begin
               cur_in = relax_x;
            end
         end
         TAG_FINAL: opt_in = dv_rd;
         default: ;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               src_in = IDX_W'(req_src);
               dst_in = IDX_W'(req_dst);
               if (req_err) begin
                  direct_in = '0;
                  best_in   = '0;
                  opt_in    = '0;
                  err_in    = 1'b1;
                  state_in  = S_RESP;
               end else if (req_tuser == REQ_WRITE) begin
                  mat_we = 1'b1;
               end else begin
                  err_in   = 1'b0;
                  mat_ra   = mat_addr(IDX_W'(req_src), IDX_W'(req_dst));
                  tag_in   = '{kind: TAG_DIRECT, idx: '0};
                  k_in     = '0;
                  phase_in = 1'b0;
                  state_in = S_TWO_HOP;
               end
            end
         end
         // Two reads per intermediate node: source row, then destination column
         S_TWO_HOP: begin
            if (!phase_ff) begin
               mat_ra   = mat_addr(src_ff, k_ff);
               tag_in   = '{kind: TAG_HOP_A, idx: k_ff};
               phase_in = 1'b1;
            end else begin
               mat_ra   = mat_addr(k_ff, dst_ff);
               tag_in   = '{kind: TAG_HOP_B, idx: k_ff};
               phase_in = 1'b0;
               if (last_k) begin
                  k_in     = '0;
                  state_in = S_INIT;
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         // Seed the distance vector, one entry a cycle
         S_INIT: begin
            dv_we = 1'b1;
            if (last_k) begin
               k_in     = '0;
               round_in = '0;
               state_in = S_BF_LOAD;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_BF_LOAD: begin
            dv_ra    = k_ff;
            tag_in   = '{kind: TAG_CUR, idx: k_ff};
            h_in     = '0;
            state_in = S_BF_RUN;
         end
         // Relax node k over every neighbor h
         S_BF_RUN: begin
            mat_ra = mat_addr(k_ff, h_ff);
            dv_ra  = h_ff;
            tag_in = '{kind: TAG_RELAX, idx: h_ff};
            if (last_h) begin
               state_in = S_BF_DRAIN;
            end else begin
               h_in = h_ff + IDX_W'(1);
            end
         end
         // Write back the relaxed distance of node k
         S_BF_DRAIN: begin
            dv_we    = 1'b1;
            dv_wd    = cur_in;
            state_in = S_BF_LOAD;
            if (last_k) begin
               k_in = '0;
               if (last_round) begin
                  state_in = S_FINAL;
               end else begin
                  round_in = round_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_FINAL: begin
            dv_ra    = src_ff;
            tag_in   = '{kind: TAG_FINAL, idx: src_ff};
            state_in = S_CAPTURE;
         end
         S_CAPTURE: state_in = S_RESP;
         // Hold the result until the output register frees up
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {FIELD_W'(opt_ff), FIELD_W'(best_ff), FIELD_W'(direct_ff)};
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tag_ff       <= '{kind: TAG_NONE, idx: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      k_ff        <= k_in;
      h_ff        <= h_in;
      round_ff    <= round_in;
      phase_ff    <= phase_in;
      a_ff        <= a_in;
      cur_ff      <= cur_in;
      direct_ff   <= direct_in;
      best_ff     <= best_in;
      opt_ff      <= opt_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

`ifndef ASSERT_OFF
   // An index error result carries no metrics
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("index error result with nonzero metrics");

   // A matrix write never lands while a query read is in flight
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      mat_we |-> (tag_ff.kind == TAG_NONE))
      else $error("matrix write during query read");

   // Relaxation data only arrives while node k is being relaxed
   a_relax_state: assert property (@(posedge clock) disable iff (reset)
      (tag_ff.kind == TAG_RELAX) |-> (state_ff == S_BF_RUN || state_ff == S_BF_DRAIN))
      else $error("relaxation data outside relaxation");

   // Relaxation indexes stay inside the active node range
   a_bf_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BF_RUN) |-> (CMP_W'(k_ff) < n_w && CMP_W'(h_ff) < n_w))
      else $error("relaxation index beyond node count");

   // A result is only raised from the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result raised outside response state");
`endif

endmodule
